### design/fra_pkg.sv
// ----------------------------------------------------------------------------
// fra_pkg: shared types and constants for the fraction arithmetic block
// Holds the operand and result widths, the operation codes, the controller
// states and the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package fra_pkg;

  // Width of each operand field (numerator or denominator).
  localparam int unsigned OPERAND_WIDTH = 16;
  // Width of raw products and sums in magnitude form.
  localparam int unsigned RAW_W = 2 * OPERAND_WIDTH;
  // Width of the result numerator and denominator.
  localparam int unsigned OUT_W = 33;
  // Counter width for the shift count and the divider step count.
  localparam int unsigned CNT_W = $clog2(RAW_W + 1);
  // Stream data widths, padded to whole bytes.
  localparam int unsigned IN_DATA_W  = ((4 * OPERAND_WIDTH + 7) / 8) * 8;
  localparam int unsigned OUT_DATA_W = ((2 * OUT_W + 7) / 8) * 8;
  localparam int unsigned KIND_W = 2;

  // Operation codes carried in the request tuser.
  typedef enum logic [KIND_W-1:0] {
    KIND_ADD = 2'd0,
    KIND_SUB = 2'd1,
    KIND_MUL = 2'd2,
    KIND_DIV = 2'd3
  } kind_e;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_COMB,
    ST_GCD,
    ST_DIV,
    ST_OUT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture a new request
    logic mul_p1;    // first product
    logic mul_p2;    // second product (cross term of add and subtract)
    logic mul_p3;    // denominator product
    logic combine;   // form raw numerator and denominator
    logic gcd_step;  // one binary gcd step
    logic div_init;  // latch divisor and start the exact divisions
    logic div_step;  // one restoring division step on both values
    logic load_raw;  // take raw values unreduced (zero raw value)
    logic out_load;  // write the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic raw_zero;  // raw numerator or denominator is zero
    logic gcd_done;  // one gcd operand has reached zero
    logic div_last;  // the current division step is the last one
  } status_t;

endpackage

### design/fra_ctrl.sv
// ----------------------------------------------------------------------------
// fra_ctrl: sequencer for the fraction arithmetic block
// Steps one request through multiply, combine, gcd and divide phases and
// owns the request ready and the result valid.
// ----------------------------------------------------------------------------
module fra_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_valid_i,
  output logic             s_ready_o,
  output logic             m_valid_o,
  input  logic             m_ready_i,
  input  fra_pkg::status_t status_i,
  output fra_pkg::cmd_t    cmd_o
);

  fra_pkg::state_e state_q, state_d;
  logic            m_valid_q, m_valid_d;
  logic            s_accept;

  assign s_ready_o = (state_q == fra_pkg::ST_IDLE);
  assign s_accept  = s_valid_i && s_ready_o;
  assign m_valid_o = m_valid_q;

  // State and result valid registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= fra_pkg::ST_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      fra_pkg::ST_IDLE: begin
        cmd_o.load = s_accept;
        if (s_accept) begin
          state_d = fra_pkg::ST_MUL1;
        end
      end
      fra_pkg::ST_MUL1: begin
        cmd_o.mul_p1 = 1'b1;
        state_d      = fra_pkg::ST_MUL2;
      end
      fra_pkg::ST_MUL2: begin
        cmd_o.mul_p2 = 1'b1;
        state_d      = fra_pkg::ST_MUL3;
      end
      fra_pkg::ST_MUL3: begin
        cmd_o.mul_p3 = 1'b1;
        state_d      = fra_pkg::ST_COMB;
      end
      fra_pkg::ST_COMB: begin
        cmd_o.combine = 1'b1;
        state_d       = fra_pkg::ST_GCD;
      end
      fra_pkg::ST_GCD: begin
        if (status_i.raw_zero) begin
          cmd_o.load_raw = 1'b1;
          state_d        = fra_pkg::ST_OUT;
        end else if (status_i.gcd_done) begin
          cmd_o.div_init = 1'b1;
          state_d        = fra_pkg::ST_DIV;
        end else begin
          cmd_o.gcd_step = 1'b1;
        end
      end
      fra_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = fra_pkg::ST_OUT;
        end
      end
      fra_pkg::ST_OUT: begin
        if (!m_valid_q || m_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = fra_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = fra_pkg::ST_IDLE;
      end
    endcase
  end

  // The output register is filled by the sequencer and drained by the sink.
  always_comb begin
    m_valid_d = m_valid_q;
    if (cmd_o.out_load) begin
      m_valid_d = 1'b1;
    end else if (m_ready_i) begin
      m_valid_d = 1'b0;
    end
  end

  // An accepted request always starts the multiply phase.
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept |=> state_q == fra_pkg::ST_MUL1)
    else $error("accepted request did not start the multiply phase");

  // A result never overwrites one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!m_valid_q || m_ready_i))
    else $error("output register overwritten while held");

  // After a result is written the controller is ready for the next request.
  a_out_then_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> (s_ready_o && m_valid_o))
    else $error("controller not idle after writing a result");

endmodule

### design/fra_datapath.sv
// ----------------------------------------------------------------------------
// fra_datapath: arithmetic for the fraction arithmetic block
// Shared operand multiplier, sign-magnitude combine, binary gcd unit, two
// bit-serial exact dividers and the result register.
// ----------------------------------------------------------------------------
module fra_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  fra_pkg::cmd_t                       cmd_i,
  output fra_pkg::status_t                    status_o,
  input  logic [fra_pkg::KIND_W-1:0]          kind_i,
  input  logic [fra_pkg::OPERAND_WIDTH-1:0]   a_num_i,
  input  logic [fra_pkg::OPERAND_WIDTH-1:0]   a_den_i,
  input  logic [fra_pkg::OPERAND_WIDTH-1:0]   b_num_i,
  input  logic [fra_pkg::OPERAND_WIDTH-1:0]   b_den_i,
  output logic [fra_pkg::OUT_W-1:0]           res_num_o,
  output logic [fra_pkg::OUT_W-1:0]           res_den_o,
  output logic                                den_zero_o
);

  localparam int unsigned W  = fra_pkg::OPERAND_WIDTH;
  localparam int unsigned RW = fra_pkg::RAW_W;
  localparam int unsigned OW = fra_pkg::OUT_W;
  localparam int unsigned CW = fra_pkg::CNT_W;

  // Captured operands in sign-magnitude form.
  fra_pkg::kind_e kind_q;
  logic           an_neg_q, ad_neg_q, bn_neg_q, bd_neg_q;
  logic [W-1:0]   an_mag_q, ad_mag_q, bn_mag_q, bd_mag_q;

  // Products.
  logic [RW-1:0]  p1_q, p2_q, p3_q;
  logic           p1_neg_q, p2_neg_q, p3_neg_q;

  // Raw result.
  logic [RW-1:0]  num_q, den_q;
  logic           num_neg_q, den_neg_q;

  // Gcd unit.
  logic [RW-1:0]  u_q, v_q;
  logic [CW-1:0]  k_q;

  // Dividers.
  logic [RW-1:0]  divisor_q, rem_n_q, rem_d_q, qn_q, qd_q;
  logic [CW-1:0]  cnt_q;

  // Result register.
  logic [OW-1:0]  res_num_q, res_den_q;
  logic           den_zero_q;

  // Combinational helpers.
  logic [W-1:0]   mul_a, mul_b;
  logic           mul_neg;
  logic [RW-1:0]  prod;
  logic           s2_neg;
  logic [RW-1:0]  num_mag_c;
  logic           num_neg_c;
  logic [RW:0]    tn, td, dv_ext;
  logic           gen_n, gen_d;
  logic [RW:0]    num_ext, den_ext;

  // Two's complement field to sign and magnitude.
  function automatic logic [W-1:0] mag_of(input logic [W-1:0] x);
    mag_of = x[W-1] ? (~x + 1'b1) : x;
  endfunction

  // Operand pair for the shared multiplier.
  always_comb begin
    mul_a   = ad_mag_q;
    mul_b   = bn_mag_q;
    mul_neg = ad_neg_q ^ bn_neg_q;
    if (cmd_i.mul_p1) begin
      mul_a = an_mag_q;
      if (kind_q == fra_pkg::KIND_MUL) begin
        mul_b   = bn_mag_q;
        mul_neg = an_neg_q ^ bn_neg_q;
      end else begin
        mul_b   = bd_mag_q;
        mul_neg = an_neg_q ^ bd_neg_q;
      end
    end else if (cmd_i.mul_p3) begin
      mul_a = ad_mag_q;
      if (kind_q == fra_pkg::KIND_DIV) begin
        mul_b   = bn_mag_q;
        mul_neg = ad_neg_q ^ bn_neg_q;
      end else begin
        mul_b   = bd_mag_q;
        mul_neg = ad_neg_q ^ bd_neg_q;
      end
    end
  end

  assign prod = RW'(mul_a) * RW'(mul_b);

  // Raw numerator: sign-magnitude add for add and subtract.
  always_comb begin
    s2_neg    = (kind_q == fra_pkg::KIND_SUB) ? !p2_neg_q : p2_neg_q;
    num_mag_c = p1_q;
    num_neg_c = p1_neg_q;
    if (kind_q == fra_pkg::KIND_ADD || kind_q == fra_pkg::KIND_SUB) begin
      if (p1_neg_q == s2_neg) begin
        num_mag_c = p1_q + p2_q;
      end else if (p1_q >= p2_q) begin
        num_mag_c = p1_q - p2_q;
      end else begin
        num_mag_c = p2_q - p1_q;
        num_neg_c = s2_neg;
      end
    end
  end

  // Restoring division step for both values against the shared divisor.
  assign dv_ext = {1'b0, divisor_q};
  assign tn     = {rem_n_q, qn_q[RW-1]};
  assign td     = {rem_d_q, qd_q[RW-1]};
  assign gen_n  = (tn >= dv_ext);
  assign gen_d  = (td >= dv_ext);

  // Operand capture and products.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q   <= fra_pkg::kind_e'(kind_i);
      an_neg_q <= a_num_i[W-1];
      ad_neg_q <= a_den_i[W-1];
      bn_neg_q <= b_num_i[W-1];
      bd_neg_q <= b_den_i[W-1];
      an_mag_q <= mag_of(a_num_i);
      ad_mag_q <= mag_of(a_den_i);
      bn_mag_q <= mag_of(b_num_i);
      bd_mag_q <= mag_of(b_den_i);
    end
    if (cmd_i.mul_p1) begin
      p1_q     <= prod;
      p1_neg_q <= mul_neg;
    end
    if (cmd_i.mul_p2) begin
      p2_q     <= prod;
      p2_neg_q <= mul_neg;
    end
    if (cmd_i.mul_p3) begin
      p3_q     <= prod;
      p3_neg_q <= mul_neg;
    end
  end

  // Raw result and binary gcd.
  always_ff @(posedge clk_i) begin
    if (cmd_i.combine) begin
      num_q     <= num_mag_c;
      num_neg_q <= num_neg_c;
      den_q     <= p3_q;
      den_neg_q <= p3_neg_q;
      u_q       <= num_mag_c;
      v_q       <= p3_q;
      k_q       <= '0;
    end else if (cmd_i.gcd_step) begin
      if (!u_q[0] && !v_q[0]) begin
        u_q <= u_q >> 1;
        v_q <= v_q >> 1;
        k_q <= k_q + 1'b1;
      end else if (!u_q[0]) begin
        u_q <= u_q >> 1;
      end else if (!v_q[0]) begin
        v_q <= v_q >> 1;
      end else if (u_q >= v_q) begin
        u_q <= u_q - v_q;
      end else begin
        v_q <= v_q - u_q;
      end
    end
  end

  // Exact division of numerator and denominator by the gcd.
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      divisor_q <= (u_q | v_q) << k_q;
      rem_n_q   <= '0;
      rem_d_q   <= '0;
      qn_q      <= num_q;
      qd_q      <= den_q;
      cnt_q     <= '0;
    end else if (cmd_i.div_step) begin
      rem_n_q <= gen_n ? RW'(tn - dv_ext) : tn[RW-1:0];
      rem_d_q <= gen_d ? RW'(td - dv_ext) : td[RW-1:0];
      qn_q    <= {qn_q[RW-2:0], gen_n};
      qd_q    <= {qd_q[RW-2:0], gen_d};
      cnt_q   <= cnt_q + 1'b1;
    end else if (cmd_i.load_raw) begin
      qn_q <= num_q;
      qd_q <= den_q;
    end
  end

  // Back to two's complement, wrapped or extended to the result width.
  assign num_ext = num_neg_q ? (~{1'b0, qn_q} + 1'b1) : {1'b0, qn_q};
  assign den_ext = den_neg_q ? (~{1'b0, qd_q} + 1'b1) : {1'b0, qd_q};

  // Result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      res_num_q  <= OW'(signed'(num_ext));
      res_den_q  <= OW'(signed'(den_ext));
      den_zero_q <= (qd_q == '0);
    end
  end

  assign status_o.raw_zero = (num_q == '0) || (den_q == '0);
  assign status_o.gcd_done = (u_q == '0) || (v_q == '0);
  assign status_o.div_last = (cnt_q == CW'(RW - 1));

  assign res_num_o  = res_num_q;
  assign res_den_o  = res_den_q;
  assign den_zero_o = den_zero_q;

  // The gcd loop only runs on two nonzero values.
  a_gcd_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.gcd_step |-> (u_q != '0 && v_q != '0))
    else $error("gcd step on a zero operand");

  // The dividers never see a zero divisor.
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> divisor_q != '0)
    else $error("division step with zero divisor");

  // The raw pair bypasses reduction only when one of its values is zero.
  a_raw_only_on_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_raw |-> (num_q == '0 || den_q == '0))
    else $error("unreduced result taken with two nonzero values");

endmodule

### design/fraction_arithmetic_reduce.sv
// ----------------------------------------------------------------------------
// fraction_arithmetic_reduce: add, subtract, multiply or divide two fractions
// Steps: the multiply states ST_MUL1 to ST_MUL3, a combine state, the binary gcd
// loop (one shift or subtract per cycle), RAW_W divider steps and an output state
// that waits while an earlier result is held; gcd and division are skipped if a raw value is zero.
// Throughput: one request at a time; the next request is taken as soon as the
// result is in the output register. Reset clears the controller and valid.
// ----------------------------------------------------------------------------
module fraction_arithmetic_reduce (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata fields from bit 0: a_num, a_den, b_num, b_den
  input  logic [fra_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // tuser fields from bit 0: kind
  input  logic [fra_pkg::KIND_W-1:0]         s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // tdata fields from bit 0: res_num, res_den, zero fill
  output logic [fra_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // tuser fields from bit 0: den_zero
  output logic [0:0]                         m_axis_tuser
);

  localparam int unsigned W  = fra_pkg::OPERAND_WIDTH;
  localparam int unsigned OW = fra_pkg::OUT_W;

  fra_pkg::cmd_t    cmd;
  fra_pkg::status_t status;
  logic [OW-1:0]    res_num, res_den;
  logic             den_zero;

  // Sequencer.
  fra_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  // Arithmetic.
  fra_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .kind_i     (s_axis_tuser),
    .a_num_i    (s_axis_tdata[W-1:0]),
    .a_den_i    (s_axis_tdata[2*W-1:W]),
    .b_num_i    (s_axis_tdata[3*W-1:2*W]),
    .b_den_i    (s_axis_tdata[4*W-1:3*W]),
    .res_num_o  (res_num),
    .res_den_o  (res_den),
    .den_zero_o (den_zero)
  );

  // Result packing with zero fill up to whole bytes.
  always_comb begin
    m_axis_tdata           = '0;
    m_axis_tdata[OW-1:0]   = res_num;
    m_axis_tdata[2*OW-1:OW] = res_den;
    m_axis_tuser[0]        = den_zero;
  end

endmodule

### tb/sv/fraction_arithmetic_reduce_tb.sv
// ----------------------------------------------------------------------------
// fraction_arithmetic_reduce_tb: stream-level regression for fraction reduce
// A directed set of edge cases is followed by about 1200 random requests.
// Each request goes through a local model of the exact cross-multiplied
// fraction and its gcd reduction. Every response is compared field by field
// against the oldest outstanding prediction. Both stream ports see random
// idle gaps and stalls, one long output hold-off and full drain pauses.
// ----------------------------------------------------------------------------
module fraction_arithmetic_reduce_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fra_pkg::*;

  localparam int unsigned RANDOM_REQUESTS = 1200;
  localparam int unsigned DRAIN_INDEX     = 600;
  localparam int unsigned HOLD_AFTER      = 400;
  localparam int unsigned HOLD_CYCLES     = 3000;
  localparam int unsigned SETTLE_CYCLES   = 250;
  localparam longint      CYCLE_LIMIT     = 3_000_000;

  // One request as presented on the input stream.
  typedef struct {
    kind_e                          kind;
    logic signed [OPERAND_WIDTH-1:0] a_num;
    logic signed [OPERAND_WIDTH-1:0] a_den;
    logic signed [OPERAND_WIDTH-1:0] b_num;
    logic signed [OPERAND_WIDTH-1:0] b_den;
    bit                             drain;  // wait for an empty pipeline first
  } fraction_request_t;

  // One reduced fraction as expected on the output stream.
  typedef struct {
    logic signed [OUT_W-1:0] num;
    logic signed [OUT_W-1:0] den;
    logic                    den_zero;
  } reduced_fraction_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic [KIND_W-1:0]     s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [0:0]            m_axis_tuser;

  fraction_request_t pending_requests[$];
  reduced_fraction_t expected_fractions[$];

  int     mismatches    = 0;
  int     responses     = 0;
  longint cycle_count   = 0;
  int     burst_left    = 0;
  int     gap_left      = 0;
  int     stall_mode    = 0;
  int     mode_left     = 0;
  int     hold_left     = 0;
  bit     hold_done     = 1'b0;

  fraction_arithmetic_reduce dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Clock generation.
  always #5 clk_i = ~clk_i;

  // Exact cross-multiplied result divided by the gcd of the magnitudes.
  function automatic reduced_fraction_t reduce_fraction(input fraction_request_t req);
    longint an, ad, bn, bd;
    longint num, den, x, y, r, g;
    reduced_fraction_t res;
    an = req.a_num;
    ad = req.a_den;
    bn = req.b_num;
    bd = req.b_den;
    case (req.kind)
      KIND_ADD: begin
        num = an * bd + ad * bn;
        den = ad * bd;
      end
      KIND_SUB: begin
        num = an * bd - ad * bn;
        den = ad * bd;
      end
      KIND_MUL: begin
        num = an * bn;
        den = ad * bd;
      end
      default: begin
        num = an * bd;
        den = ad * bn;
      end
    endcase
    x = (num < 0) ? -num : num;
    y = (den < 0) ? -den : den;
    // A zero on either side leaves the raw pair unreduced.
    if (x == 0 || y == 0) begin
      g = 1;
    end else begin
      while (x % y != 0) begin
        r = x % y;
        x = y;
        y = r;
      end
      g = y;
    end
    num = num / g;
    den = den / g;
    res.num      = num[OUT_W-1:0];
    res.den      = den[OUT_W-1:0];
    res.den_zero = (den == 0);
    return res;
  endfunction

  // Operand values biased toward zero, unit, extreme and small values.
  function automatic logic signed [OPERAND_WIDTH-1:0] pick_operand();
    logic signed [OPERAND_WIDTH-1:0] v;
    case ($urandom_range(0, 9))
      0:       v = '0;
      1:       v = $urandom_range(0, 1) ? 16'sd1 : -16'sd1;
      2: begin
        case ($urandom_range(0, 2))
          0:       v = 16'sh8000;
          1:       v = 16'sh7fff;
          default: v = 16'sh8001;
        endcase
      end
      3, 4, 5: v = $signed(16'($urandom_range(0, 40))) - 16'sd20;
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  task automatic queue_request(input kind_e kind,
                               input logic signed [OPERAND_WIDTH-1:0] a_num,
                               input logic signed [OPERAND_WIDTH-1:0] a_den,
                               input logic signed [OPERAND_WIDTH-1:0] b_num,
                               input logic signed [OPERAND_WIDTH-1:0] b_den,
                               input bit drain);
    fraction_request_t req;
    req.kind  = kind;
    req.a_num = a_num;
    req.a_den = a_den;
    req.b_num = b_num;
    req.b_den = b_den;
    req.drain = drain;
    pending_requests.push_back(req);
  endtask

  // Request source: bursts of back-to-back requests separated by random gaps.
  always @(posedge clk_i or negedge rst_ni) begin : request_driver
    fraction_request_t req;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (gap_left != 0) begin
        gap_left      <= gap_left - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pending_requests.size() == 0) begin
        s_axis_tvalid <= 1'b0;
      end else if (pending_requests[0].drain &&
                   (s_axis_tvalid || expected_fractions.size() != 0)) begin
        // Hold the next request until every outstanding result is back.
        s_axis_tvalid <= 1'b0;
      end else begin
        req = pending_requests.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {req.b_den, req.b_num, req.a_den, req.a_num};
        s_axis_tuser  <= req.kind;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 16);
          case ($urandom_range(0, 3))
            0:       gap_left <= 0;
            1:       gap_left <= $urandom_range(1, 5);
            2:       gap_left <= $urandom_range(5, 60);
            default: gap_left <= $urandom_range(60, 200);
          endcase
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // Result sink: stall patterns that change at random, plus one long hold-off.
  always @(posedge clk_i or negedge rst_ni) begin : response_sink
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!hold_done && responses >= HOLD_AFTER) begin
      hold_done     <= 1'b1;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 2);
        mode_left  <= $urandom_range(50, 2000);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= $urandom_range(0, 1);
        default: m_axis_tready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  // Check each response against the oldest prediction, then record new requests.
  always @(posedge clk_i) begin : scoreboard
    fraction_request_t req;
    reduced_fraction_t want;
    logic signed [OUT_W-1:0] got_num;
    logic signed [OUT_W-1:0] got_den;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_num = m_axis_tdata[OUT_W-1:0];
        got_den = m_axis_tdata[2*OUT_W-1:OUT_W];
        responses = responses + 1;
        if (expected_fractions.size() == 0) begin
          $error("unexpected response: res_num %0d res_den %0d", got_num, got_den);
          mismatches = mismatches + 1;
        end else begin
          want = expected_fractions.pop_front();
          if (got_num !== want.num) begin
            $error("res_num: expected %0d, actual %0d", want.num, got_num);
            mismatches = mismatches + 1;
          end
          if (got_den !== want.den) begin
            $error("res_den: expected %0d, actual %0d", want.den, got_den);
            mismatches = mismatches + 1;
          end
          if (m_axis_tuser[0] !== want.den_zero) begin
            $error("den_zero: expected %0b, actual %0b", want.den_zero, m_axis_tuser[0]);
            mismatches = mismatches + 1;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        req.kind  = kind_e'(s_axis_tuser);
        req.a_num = s_axis_tdata[OPERAND_WIDTH-1:0];
        req.a_den = s_axis_tdata[2*OPERAND_WIDTH-1:OPERAND_WIDTH];
        req.b_num = s_axis_tdata[3*OPERAND_WIDTH-1:2*OPERAND_WIDTH];
        req.b_den = s_axis_tdata[4*OPERAND_WIDTH-1:3*OPERAND_WIDTH];
        req.drain = 1'b0;
        expected_fractions.push_back(reduce_fraction(req));
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Stimulus, reset and end of test.
  initial begin : stimulus
    kind_e kind;
    // Hand-picked cases: every operation, zero operands and the extremes.
    queue_request(KIND_ADD, 16'sd1, 16'sd2, 16'sd1, 16'sd3, 1'b0);
    queue_request(KIND_SUB, 16'sd1, 16'sd2, 16'sd1, 16'sd2, 1'b0);
    queue_request(KIND_MUL, 16'sd2, 16'sd3, 16'sd3, 16'sd4, 1'b0);
    queue_request(KIND_DIV, 16'sd1, 16'sd2, 16'sd3, 16'sd4, 1'b0);
    queue_request(KIND_DIV, 16'sd1, 16'sd2, 16'sd0, 16'sd5, 1'b0);
    queue_request(KIND_ADD, 16'sd1, 16'sd0, 16'sd1, 16'sd3, 1'b0);
    queue_request(KIND_MUL, 16'sd0, 16'sd7, 16'sd3, 16'sd5, 1'b0);
    queue_request(KIND_SUB, 16'sd0, 16'sd6, 16'sd0, 16'sd4, 1'b0);
    queue_request(KIND_ADD, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1'b0);
    queue_request(KIND_SUB, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000, 1'b0);
    queue_request(KIND_MUL, 16'sh8000, 16'sd1, 16'sh8000, 16'sd1, 1'b0);
    queue_request(KIND_DIV, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 1'b0);
    queue_request(KIND_ADD, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0);
    queue_request(KIND_ADD, 16'sd3, -16'sd6, 16'sd1, -16'sd2, 1'b0);
    queue_request(KIND_DIV, -16'sd1, 16'sd1, -16'sd1, -16'sd1, 1'b0);
    queue_request(KIND_SUB, 16'sh8000, -16'sd1, 16'sh7fff, 16'sd1, 1'b0);
    queue_request(KIND_ADD, 16'sd1, 16'sh8000, -16'sd1, 16'sh7fff, 1'b0);
    queue_request(KIND_ADD, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0);
    queue_request(KIND_SUB, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0);
    queue_request(KIND_MUL, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0);
    queue_request(KIND_DIV, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0);
    queue_request(KIND_DIV, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 1'b0);
    queue_request(KIND_MUL, -16'sd12, 16'sd18, 16'sd15, -16'sd20, 1'b0);
    // Random part; request DRAIN_INDEX and rare random others wait for an empty pipeline.
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      kind = kind_e'($urandom_range(0, 3));
      queue_request(kind, pick_operand(), pick_operand(), pick_operand(), pick_operand(),
                    (i == DRAIN_INDEX) || ($urandom_range(0, 299) == 0));
    end

    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (pending_requests.size() == 0 && !s_axis_tvalid);
    wait (expected_fractions.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (mismatches == 0 && expected_fractions.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
